>>> sv/amct_pkg.sv
// Shared types and constants of the argmax class transition counter.
// Holds the action and result codes, field widths and the stage control struct.
// No dependencies.
package amct_pkg;

   localparam int ACT_W   = 2;
   localparam int PROB_W  = 16;
   localparam int COUNT_W = 32;

   localparam logic [ACT_W-1:0] ACT_ELEM  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef struct packed {
      logic report;
      logic read;
      logic counted;
      logic rd_ok;
   } amct_op_type;

endpackage

>>> sv/amct_track.sv
// Running argmax, element index and previous class tracking for the first stage.
// Decodes the staged word into a count store address and the stage control struct.
// Depends on amct_pkg.
module amct_track import amct_pkg::*; #(
   parameter int MAX_CLASSES = 16,
   localparam int CLS_W = $clog2(MAX_CLASSES),
   localparam int NC_W  = $clog2(MAX_CLASSES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               restart,
   input  logic [NC_W-1:0]    nc,
   input  logic [ACT_W-1:0]   action,
   input  logic [PROB_W-1:0]  prob,
   input  logic               last,
   input  logic [CLS_W-1:0]   row,
   input  logic [CLS_W-1:0]   col,
   output amct_op_type        op,
   output logic [2*CLS_W-1:0] addr,
   output logic [CLS_W-1:0]   winner
);

   logic [PROB_W-1:0] max_ff, max_in;
   logic [CLS_W-1:0]  argmax_ff;
   logic [NC_W-1:0]   idx_ff;
   logic [CLS_W-1:0]  prev_ff;
   logic              prev_valid_ff;
   logic              elem;
   logic              take;
   logic              better;

   assign elem   = (action == ACT_ELEM);
   assign take   = (idx_ff < nc);
   assign better = (idx_ff == '0) || (prob > max_ff);
   assign max_in = (take && better) ? prob : max_ff;
   assign winner = (take && better) ? idx_ff[CLS_W-1:0] : argmax_ff;

   always_comb begin
      op.report  = elem && last;
      op.read    = (action == ACT_READ);
      op.counted = elem && last && prev_valid_ff && (NC_W'(prev_ff) < nc)
                   && (NC_W'(winner) < nc);
      op.rd_ok   = (NC_W'(row) < nc) && (NC_W'(col) < nc);
      addr       = op.read ? {row, col} : {prev_ff, winner};
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         max_ff        <= '0;
         argmax_ff     <= '0;
         idx_ff        <= '0;
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
      end else if (step) begin
         if (elem && last) begin
            max_ff        <= '0;
            argmax_ff     <= '0;
            idx_ff        <= '0;
            prev_ff       <= winner;
            prev_valid_ff <= 1'b1;
         end else if (elem) begin
            max_ff    <= max_in;
            argmax_ff <= winner;
            if (take) begin
               idx_ff <= idx_ff + NC_W'(1);
            end
         end else if (action == ACT_CLEAR) begin
            prev_ff       <= '0;
            prev_valid_ff <= 1'b0;
         end
      end
   end

   a_prev_in_range: assert property (@(posedge clock) disable iff (reset)
      prev_valid_ff |-> (NC_W'(prev_ff) < nc))
      else $error("previous class outside the classes in use");

endmodule

>>> sv/amct_count_mem.sv
// Transition count store with read-modify-write increment, write forwarding
// and a zeroing sweep after reset, clear words and register writes.
// Depends on amct_pkg.
module amct_count_mem import amct_pkg::*; #(
   parameter int MAX_CLASSES = 16,
   localparam int CLS_W = $clog2(MAX_CLASSES),
   localparam int AW    = 2 * CLS_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               inc_req,
   input  logic [AW-1:0]      rd_addr,
   input  logic               clear_start,
   output logic [COUNT_W-1:0] count_data,
   output logic               sweep_busy
);

   logic [COUNT_W-1:0] count_mem_ff [1 << AW];
   logic [COUNT_W-1:0] rdata_ff;
   logic [COUNT_W-1:0] fwd_data_ff;
   logic               fwd_ff;
   logic               inc_ff;
   logic [AW-1:0]      inc_addr_ff;
   logic [AW-1:0]      sweep_addr_ff;
   logic               sweep_busy_ff;
   logic               wr_en;
   logic [COUNT_W-1:0] wr_data;

   assign count_data = fwd_ff ? fwd_data_ff : rdata_ff;
   assign wr_en      = advance && inc_ff;
   assign wr_data    = count_data + COUNT_W'(1);
   assign sweep_busy = sweep_busy_ff;

   always_ff @(posedge clock) begin
      if (reset || clear_start) begin
         sweep_busy_ff <= 1'b1;
         sweep_addr_ff <= '0;
      end else if (sweep_busy_ff) begin
         sweep_addr_ff <= sweep_addr_ff + AW'(1);
         if (sweep_addr_ff == '1) begin
            sweep_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else if (advance) begin
         inc_ff <= inc_req;
         fwd_ff <= wr_en && (inc_addr_ff == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         inc_addr_ff <= rd_addr;
         fwd_data_ff <= wr_data;
         rdata_ff    <= count_mem_ff[rd_addr];
      end
      if (sweep_busy_ff) begin
         count_mem_ff[sweep_addr_ff] <= '0;
      end else if (wr_en) begin
         count_mem_ff[inc_addr_ff] <= wr_data;
      end
   end

   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_busy_ff |-> !wr_en)
      else $error("count increment during zeroing sweep");

endmodule

>>> sv/argmax_class_transition_counter.sv
// Top level of the argmax class transition counter.
// Instantiates amct_track and amct_count_mem; depends on amct_pkg.
// Accepts one word per cycle while req_stall is low; each result passes the stage register,
// the count store read register and the output register, in that order.
// After reset, a clear word or a write of the class count register the count store is
// zeroed by a sweep over its 2**(2*clog2(MAX_CLASSES)) words (256 at the default), during
// which req_stall stays high; a clear word also holds the input while it is staged.
module argmax_class_transition_counter import amct_pkg::*; #(
   parameter int MAX_CLASSES = 16,
   localparam int CLS_W = $clog2(MAX_CLASSES),
   localparam int NC_W  = $clog2(MAX_CLASSES + 1),
   localparam int NC_RESET = (MAX_CLASSES < 16) ? MAX_CLASSES : 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [NC_W-1:0]    csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [ACT_W-1:0]   req_action,
   input  logic [PROB_W-1:0]  req_prob,
   input  logic               req_last,
   input  logic [CLS_W-1:0]   req_read_row,
   input  logic [CLS_W-1:0]   req_read_col,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [CLS_W-1:0]   rsp_winner_class,
   output logic               rsp_counted,
   output logic [COUNT_W-1:0] rsp_count_value
);

   logic [NC_W-1:0]    nc_ff, nc_in;
   logic               s1_valid_ff;
   logic [ACT_W-1:0]   s1_action_ff;
   logic [PROB_W-1:0]  s1_prob_ff;
   logic               s1_last_ff;
   logic [CLS_W-1:0]   s1_row_ff;
   logic [CLS_W-1:0]   s1_col_ff;
   logic               s2_valid_ff;
   amct_op_type        s2_op_ff;
   logic [CLS_W-1:0]   s2_winner_ff;
   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [CLS_W-1:0]   rsp_winner_ff;
   logic               rsp_counted_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               advance;
   logic               step;
   logic               s1_clear;
   logic               accept;
   logic               sweep_busy;
   amct_op_type        s1_op;
   logic [2*CLS_W-1:0] s1_addr;
   logic [CLS_W-1:0]   s1_winner;
   logic [COUNT_W-1:0] count_data;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = advance && s1_valid_ff;
   assign s1_clear  = s1_valid_ff && (s1_action_ff == ACT_CLEAR);
   assign req_stall = !advance || sweep_busy || s1_clear;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (csr_wr_data == '0) begin
         nc_in = NC_W'(1);
      end else if (csr_wr_data > NC_W'(MAX_CLASSES)) begin
         nc_in = NC_W'(MAX_CLASSES);
      end else begin
         nc_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff <= NC_W'(NC_RESET);
      end else if (csr_wr_en) begin
         nc_ff <= nc_in;
      end
   end

   amct_track #(.MAX_CLASSES(MAX_CLASSES)) u_track (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .restart (csr_wr_en),
      .nc      (nc_ff),
      .action  (s1_action_ff),
      .prob    (s1_prob_ff),
      .last    (s1_last_ff),
      .row     (s1_row_ff),
      .col     (s1_col_ff),
      .op      (s1_op),
      .addr    (s1_addr),
      .winner  (s1_winner)
   );

   amct_count_mem #(.MAX_CLASSES(MAX_CLASSES)) u_count_mem (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .inc_req     (step && s1_op.counted),
      .rd_addr     (s1_addr),
      .clear_start (csr_wr_en || (advance && s1_clear)),
      .count_data  (count_data),
      .sweep_busy  (sweep_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff && (s2_op_ff.report || s2_op_ff.read);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (accept) begin
            s1_action_ff <= req_action;
            s1_prob_ff   <= req_prob;
            s1_last_ff   <= req_last;
            s1_row_ff    <= req_read_row;
            s1_col_ff    <= req_read_col;
         end
         s2_op_ff       <= s1_op;
         s2_winner_ff   <= s1_winner;
         rsp_kind_ff    <= s2_op_ff.read ? KIND_READ : KIND_REPORT;
         rsp_winner_ff  <= s2_op_ff.read ? '0 : s2_winner_ff;
         rsp_counted_ff <= s2_op_ff.read ? 1'b0 : s2_op_ff.counted;
         rsp_count_ff   <= (s2_op_ff.read && s2_op_ff.rd_ok) ? count_data : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_winner_class = rsp_winner_ff;
   assign rsp_counted      = rsp_counted_ff;
   assign rsp_count_value  = rsp_count_ff;

   a_front_empty_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_busy |-> !s1_valid_ff)
      else $error("word staged while the count store is being zeroed");

   a_report_no_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_REPORT)) |-> (rsp_count_ff == '0))
      else $error("vector report carries a count value");

endmodule
